>>> rtl/sfp_pkg.sv
// Shared constants, types and the CRC-8 fold for the framed byte parser.
// Used by every module of serial_frame_parser_crc8; depends on nothing.
package sfp_pkg;

  localparam int PAYLOAD_LEN = 24;
  localparam int IDX_W       = 6;
  localparam int LEN_AW      = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
  localparam int MEM_AW      = LEN_AW + 1;
  localparam int MEM_DEPTH   = 1 << MEM_AW;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED   = 2'd1;

  localparam logic [7:0]  START_BYTE_RESET = 8'hA5;
  localparam logic [7:0]  CRC_SEED_RESET   = 8'h00;
  localparam logic [7:0]  CRC_POLY         = 8'h07;
  localparam logic [15:0] ERR_MAX          = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic        err;
    logic        bank;
    logic [15:0] err_total;
  } frame_cmd_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last_of_run;
    logic             frame_status;
    logic [15:0]      error_total;
  } result_t;

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

>>> rtl/sfp_front.sv
// Front end: config registers, start-byte hunt, CRC-8 and payload capture.
// Writes payload bytes into one of two store banks and pushes frame commands.
// Depends on sfp_pkg.
module sfp_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic [7:0]                     in_rx_byte,
  output logic                           in_full,
  input  logic                           cfg_valid,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_wdata,
  input  logic                           cmd_full,
  input  sfp_pkg::bank_rel_t             rel,
  output logic                           cmd_push,
  output sfp_pkg::frame_cmd_t            cmd,
  output sfp_pkg::mem_wr_t               mem_wr
);

  logic [7:0]                  start_byte_r;
  logic [7:0]                  crc_seed_r;
  sfp_pkg::phase_t             phase_r, phase_nxt;
  logic [7:0]                  crc_r, crc_nxt;
  logic [sfp_pkg::IDX_W-1:0]   fill_r, fill_nxt;
  logic                        bank_r, bank_nxt;
  logic [1:0]                  busy_r, busy_nxt;
  logic [15:0]                 err_cnt_r, err_cnt_nxt;

  logic                        acc;
  logic [7:0]                  fold;
  logic [15:0]                 err_inc;
  logic                        set_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= sfp_pkg::START_BYTE_RESET;
      crc_seed_r   <= sfp_pkg::CRC_SEED_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == sfp_pkg::CFG_START_BYTE) begin
        start_byte_r <= cfg_wdata;
      end else if (cfg_index == sfp_pkg::CFG_CRC_SEED) begin
        crc_seed_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= sfp_pkg::PH_IDLE;
      crc_r     <= '0;
      fill_r    <= '0;
      bank_r    <= 1'b0;
      busy_r    <= '0;
      err_cnt_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      crc_r     <= crc_nxt;
      fill_r    <= fill_nxt;
      bank_r    <= bank_nxt;
      busy_r    <= busy_nxt;
      err_cnt_r <= err_cnt_nxt;
    end
  end

  always_comb begin
    in_full = ((phase_r == sfp_pkg::PH_PAYLOAD) && busy_r[bank_r]) ||
              ((phase_r == sfp_pkg::PH_CHECK) && cmd_full);
    acc     = in_push && !in_full;
    fold    = sfp_pkg::crc8_fold((phase_r == sfp_pkg::PH_PAYLOAD) ? crc_r : crc_seed_r,
                                 in_rx_byte);
    err_inc = (err_cnt_r == sfp_pkg::ERR_MAX) ? err_cnt_r : err_cnt_r + 16'd1;

    phase_nxt   = phase_r;
    crc_nxt     = crc_r;
    fill_nxt    = fill_r;
    bank_nxt    = bank_r;
    err_cnt_nxt = err_cnt_r;
    set_busy    = 1'b0;
    cmd_push    = 1'b0;
    cmd         = '{err: 1'b0, bank: bank_r, err_total: err_cnt_r};
    mem_wr      = '{en: 1'b0, addr: {bank_r, fill_r[sfp_pkg::LEN_AW-1:0]}, data: in_rx_byte};

    unique case (phase_r)
      sfp_pkg::PH_PAYLOAD: begin
        if (acc) begin
          crc_nxt   = fold;
          mem_wr.en = 1'b1;
          if (fill_r == sfp_pkg::LAST_IDX) begin
            fill_nxt  = '0;
            phase_nxt = sfp_pkg::PH_CHECK;
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      sfp_pkg::PH_CHECK: begin
        if (acc) begin
          cmd_push  = 1'b1;
          phase_nxt = sfp_pkg::PH_IDLE;
          if (in_rx_byte == crc_r) begin
            set_busy = 1'b1;
            bank_nxt = ~bank_r;
          end else begin
            cmd.err       = 1'b1;
            cmd.err_total = err_inc;
            err_cnt_nxt   = err_inc;
          end
        end
      end
      default: begin
        if (acc) begin
          phase_nxt = sfp_pkg::PH_IDLE;
          if (in_rx_byte == start_byte_r) begin
            crc_nxt   = fold;
            fill_nxt  = '0;
            phase_nxt = sfp_pkg::PH_PAYLOAD;
          end
        end
      end
    endcase

    busy_nxt = busy_r;
    if (rel.en) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (set_busy) begin
      busy_nxt[bank_r] = 1'b1;
    end
  end

endmodule

>>> rtl/sfp_cmd_fifo.sv
// Two-entry queue of frame commands between the front and back ends.
// Depends on sfp_pkg.
module sfp_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sfp_pkg::frame_cmd_t  wr_cmd,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output sfp_pkg::frame_cmd_t  head
);

  sfp_pkg::frame_cmd_t  slot_r [2];
  logic                 wp_r, rp_r;
  logic [1:0]           cnt_r;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = slot_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

>>> rtl/sfp_back.sv
// Back end: two-bank payload store, read sequencer and two-entry result queue.
// Drains one frame command at a time; depends on sfp_pkg.
module sfp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfp_pkg::mem_wr_t     mem_wr,
  input  logic                 cmd_empty,
  input  sfp_pkg::frame_cmd_t  cmd,
  output logic                 cmd_pop,
  output sfp_pkg::bank_rel_t   rel,
  input  logic                 out_pop,
  output logic                 out_empty,
  output sfp_pkg::result_t     result
);

  logic [7:0]                  mem [sfp_pkg::MEM_DEPTH];
  logic [7:0]                  rd_q_r;
  logic [sfp_pkg::IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                        pend_r;
  sfp_pkg::result_t            pend_meta_r;
  sfp_pkg::result_t            ob_r [2];
  logic                        ob_wp_r, ob_rp_r;
  logic [1:0]                  ob_cnt_r;

  logic                        pop_fire;
  logic [1:0]                  occ;
  logic                        issue;
  logic                        at_last;
  sfp_pkg::result_t            meta;
  sfp_pkg::result_t            ob_in;

  always_comb begin
    pop_fire = out_pop && (ob_cnt_r != 2'd0);
    occ      = ob_cnt_r + {1'b0, pend_r};
    issue    = !cmd_empty && ((occ < 2'd2) || (pop_fire && (occ == 2'd2)));
    at_last  = (rd_idx_r == sfp_pkg::LAST_IDX);

    meta.payload_byte = '0;
    meta.byte_index   = cmd.err ? '0 : rd_idx_r;
    meta.last_of_run  = cmd.err || at_last;
    meta.frame_status = cmd.err;
    meta.error_total  = cmd.err_total;

    cmd_pop  = issue && (cmd.err || at_last);
    rel.en   = issue && !cmd.err && at_last;
    rel.bank = cmd.bank;

    rd_idx_nxt = rd_idx_r;
    if (issue && !cmd.err) begin
      rd_idx_nxt = at_last ? '0 : rd_idx_r + 1'b1;
    end

    ob_in              = pend_meta_r;
    ob_in.payload_byte = pend_meta_r.frame_status ? 8'd0 : rd_q_r;

    out_empty = (ob_cnt_r == 2'd0);
    result    = ob_r[ob_rp_r];
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
    if (issue) begin
      rd_q_r <= mem[{cmd.bank, rd_idx_r[sfp_pkg::LEN_AW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_meta_r <= meta;
    end
    if (pend_r) begin
      ob_r[ob_wp_r] <= ob_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      pend_r   <= 1'b0;
      ob_wp_r  <= 1'b0;
      ob_rp_r  <= 1'b0;
      ob_cnt_r <= '0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
      pend_r   <= issue;
      if (pend_r) begin
        ob_wp_r <= ~ob_wp_r;
      end
      if (pop_fire) begin
        ob_rp_r <= ~ob_rp_r;
      end
      ob_cnt_r <= ob_cnt_r + {1'b0, pend_r} - {1'b0, pop_fire};
    end
  end

endmodule

>>> rtl/serial_frame_parser_crc8.sv
// Top level of the start-byte framed parser with CRC-8 check.
// Instantiates sfp_front, sfp_cmd_fifo and sfp_back; depends on sfp_pkg.
//
//   channel  handshake            payload
//   in       in_push / in_full    in_rx_byte
//   out      out_pop / out_empty  out_payload_byte, out_byte_index, out_last_of_run,
//                                 out_frame_status, out_error_total
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_wdata
//
// One byte per cycle is taken while in_full is low; a byte is classified, and a
// start or payload byte folded into the CRC, in the cycle it is accepted. A good
// frame drains one result per cycle from a two-bank payload store unless the
// result queue backs up. A payload byte stalls while the bank it would fill still
// holds a frame not yet drained; a check byte stalls while the two-entry command
// queue is full. Start and idle bytes never stall. Synchronous reset clears all
// control state at once; the store needs no clearing pass. cfg_ready stays high.
module serial_frame_parser_crc8 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [7:0]                     out_payload_byte,
  output logic [sfp_pkg::IDX_W-1:0]      out_byte_index,
  output logic                           out_last_of_run,
  output logic                           out_frame_status,
  output logic [15:0]                    out_error_total,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_wdata
);

  logic                 cmd_full;
  logic                 cmd_empty;
  logic                 cmd_push;
  logic                 cmd_pop;
  sfp_pkg::frame_cmd_t  cmd_wr;
  sfp_pkg::frame_cmd_t  cmd_head;
  sfp_pkg::bank_rel_t   rel;
  sfp_pkg::mem_wr_t     mem_wr;
  sfp_pkg::result_t     result;

  assign cfg_ready = 1'b1;

  sfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd_full   (cmd_full),
    .rel        (rel),
    .cmd_push   (cmd_push),
    .cmd        (cmd_wr),
    .mem_wr     (mem_wr)
  );

  sfp_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wr_cmd (cmd_wr),
    .full   (cmd_full),
    .pop    (cmd_pop),
    .empty  (cmd_empty),
    .head   (cmd_head)
  );

  sfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mem_wr    (mem_wr),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .rel       (rel),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .result    (result)
  );

  assign out_payload_byte = result.payload_byte;
  assign out_byte_index   = result.byte_index;
  assign out_last_of_run  = result.last_of_run;
  assign out_frame_status = result.frame_status;
  assign out_error_total  = result.error_total;

endmodule
